// ----- rtl/btcm_pkg.sv -----
// shared types and constants of the bilevel template context model
package btcm_pkg;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned RowLimit   = 4096;
  localparam int unsigned ColBits    = $clog2(MaxWidth);
  localparam int unsigned RowBits    = $clog2(RowLimit);
  localparam int unsigned WidthBits  = 11;
  localparam int unsigned HeightBits = 13;
  localparam int unsigned InitBits   = 16;
  localparam int unsigned StepBits   = 12;
  localparam int unsigned LimitBits  = 16;
  localparam int unsigned CfgBits    = 16;
  localparam int unsigned RegIdxBits = 3;

  localparam int unsigned TableSize  = 1047551;
  localparam int unsigned CtxBits    = $clog2(TableSize);
  localparam int unsigned FoldMul    = (1 << CtxBits) - TableSize;
  localparam int unsigned DigitRadix = 3;
  localparam int unsigned TmplLen    = 10;
  localparam int unsigned PackBits   = 16;
  localparam int unsigned HashMul    = 713;
  localparam int unsigned HashBits   = 26;
  localparam int unsigned CountBits  = 17;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrBits   = $clog2(QueueDepth);

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_CLEAR = 1'b1
  } action_e;

  typedef enum logic [RegIdxBits-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_INIT   = 3'd2,
    REG_STEP   = 3'd3,
    REG_LIMIT  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [WidthBits-1:0]  width;
    logic [HeightBits-1:0] height;
    logic [InitBits-1:0]   init;
    logic [StepBits-1:0]   step;
    logic [LimitBits-1:0]  limit;
  } cfg_t;

  // one word passed from the front to the back
  typedef struct packed {
    action_e              action;
    logic                 pixel;
    logic                 mark_end;
    logic [CtxBits-1:0]   ctx;
  } work_t;

endpackage

// ----- rtl/bilevel_template_context_model.sv -----
// top level of the bilevel template context model
//
//  channel     dir  handshake              payload
//  s_axis      in   tvalid/tready          tdata[0] pixel, tuser action
//  m_axis      out  tvalid/tready          tdata context/white/black, tlast, tuser
//  cfg         in   cfg_we_i (no stall)    cfg_idx_i, cfg_data_i
//
// a pixel word enters each cycle inside a row unless the pipe stalls; each row start
// costs a line-store prefetch through its single read port.
// a clear word sweeps the count table through its one write port before its
// result appears.
// reset leaves the count table as it is: send a clear word before pixels.
// a four-word queue lets the front run on while the output register stalls.
module bilevel_template_context_model import btcm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [0] pixel, [7:1] zero
  input  logic                  s_axis_tuser,   // [0] action
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [55:0]           m_axis_tdata,   // [19:0] context, [36:20] white, [53:37] black
  output logic                  m_axis_tlast,
  output logic                  m_axis_tuser,   // [0] clear done
  input  logic                  cfg_we_i,
  input  logic [RegIdxBits-1:0] cfg_idx_i,
  input  logic [CfgBits-1:0]    cfg_data_i
);

  cfg_t                 cfg_q;
  logic                 q_push, q_full, q_pop, q_valid;
  work_t                q_in, q_out;
  logic [CtxBits-1:0]   out_ctx;
  logic [CountBits-1:0] out_white, out_black;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= WidthBits'(1);
      cfg_q.height <= HeightBits'(1);
      cfg_q.init   <= InitBits'(1);
      cfg_q.step   <= StepBits'(1);
      cfg_q.limit  <= LimitBits'(65535);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:  cfg_q.width  <= cfg_data_i[WidthBits-1:0];
        REG_HEIGHT: cfg_q.height <= cfg_data_i[HeightBits-1:0];
        REG_INIT:   cfg_q.init   <= cfg_data_i[InitBits-1:0];
        REG_STEP:   cfg_q.step   <= cfg_data_i[StepBits-1:0];
        REG_LIMIT:  cfg_q.limit  <= cfg_data_i[LimitBits-1:0];
        default:    cfg_q        <= cfg_q;
      endcase
    end
  end

  btcm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (action_e'(s_axis_tuser)),
    .in_pixel_i  (s_axis_tdata[0]),
    .push_o      (q_push),
    .work_o      (q_in),
    .full_i      (q_full)
  );

  btcm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .work_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .work_o  (q_out)
  );

  btcm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_work_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_ctx_o   (out_ctx),
    .out_white_o (out_white),
    .out_black_o (out_black),
    .out_last_o  (m_axis_tlast),
    .out_clear_o (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, out_black, out_white, out_ctx};

  a_queue_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full || q_pop)
    else $error("word pushed into a full queue");

  a_queue_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("word popped from an empty queue");

  a_clear_word_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0 && !m_axis_tlast))
    else $error("clear result carries pixel fields");

  a_ctx_in_table : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (out_ctx < CtxBits'(TableSize)))
    else $error("context index beyond the count table");

endmodule

// ----- rtl/btcm_front.sv -----
// front: position tracking, line stores, template digits and context hash
module btcm_front import btcm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  action_e in_action_i,
  input  logic    in_pixel_i,
  output logic    push_o,
  output work_t   work_o,
  input  logic    full_i
);

  typedef struct packed {
    logic above;
    logic two;
  } lpair_t;

  localparam int unsigned PrefetchLen = 3;
  localparam logic [PackBits-1:0] Pow3 [TmplLen] = '{
    16'd19683, 16'd6561, 16'd2187, 16'd729, 16'd243,
    16'd81, 16'd27, 16'd9, 16'd3, 16'd1
  };

  logic [WidthBits-1:0]  eff_w;
  logic [HeightBits-1:0] eff_h;
  logic [ColBits-1:0]    col_q, col_d;
  logic [RowBits-1:0]    row_q, row_d;
  logic [1:0]            left_q, left_d;
  logic                  pf_on_q, pf_on_d;
  logic [1:0]            pf_cnt_q, pf_cnt_d;

  lpair_t                lstore_q [MaxWidth];
  lpair_t                rd_q;
  lpair_t                win_q [4];
  logic                  ls_re, ls_we;
  logic [ColBits-1:0]    ls_raddr;

  logic                  accept, accept_pix;
  logic [WidthBits-1:0]  xw;
  logic [HeightBits-1:0] yw;
  logic                  cm2, cm1, c0, cp1, cp2, rm2, rm1, r0;
  logic                  last_col, last_row;
  logic [1:0]            dig [TmplLen];
  logic [TmplLen-1:0]    dbit, dok;
  logic [PackBits-1:0]   pack;

  logic                  s1_v_q, s2_v_q, s3_v_q;
  work_t                 s1_q, s2_q, s3_q;
  logic [PackBits-1:0]   s1_pack_q;
  logic [HashBits-1:0]   s2_hash_q;
  logic                  ld2, ld3;
  logic [PackBits:0]     hsum;
  logic [HashBits:0]     hprod;
  logic [CtxBits:0]      fold;
  logic [CtxBits-1:0]    ctx;

  // effective size: zero counts as one, large values saturate
  always_comb begin
    eff_w = cfg_i.width;
    if (cfg_i.width == '0) begin
      eff_w = WidthBits'(1);
    end else if (cfg_i.width > WidthBits'(MaxWidth)) begin
      eff_w = WidthBits'(MaxWidth);
    end
    eff_h = cfg_i.height;
    if (cfg_i.height == '0) begin
      eff_h = HeightBits'(1);
    end else if (cfg_i.height > HeightBits'(RowLimit)) begin
      eff_h = HeightBits'(RowLimit);
    end
  end

  // elastic three stage pipe
  assign push_o     = s3_v_q && !full_i;
  assign ld3        = s2_v_q && (!s3_v_q || push_o);
  assign ld2        = s1_v_q && (!s2_v_q || ld3);
  assign in_ready_o = !pf_on_q && (!s1_v_q || ld2);
  assign accept     = in_valid_i && in_ready_o;
  assign accept_pix = accept && (in_action_i == ACT_PIXEL);

  // neighbor bounds
  always_comb begin
    xw  = {1'b0, col_q};
    yw  = {1'b0, row_q};
    cm2 = (col_q >= ColBits'(2)) && ((xw - WidthBits'(2)) < eff_w);
    cm1 = (col_q >= ColBits'(1)) && ((xw - WidthBits'(1)) < eff_w);
    c0  = xw < eff_w;
    cp1 = (xw + WidthBits'(1)) < eff_w;
    cp2 = (xw + WidthBits'(2)) < eff_w;
    rm2 = (row_q >= RowBits'(2)) && ((yw - HeightBits'(2)) < eff_h);
    rm1 = (row_q >= RowBits'(1)) && ((yw - HeightBits'(1)) < eff_h);
    r0  = yw < eff_h;
    last_col = (xw + WidthBits'(1)) >= eff_w;
    last_row = (yw + HeightBits'(1)) >= eff_h;
  end

  // window holds columns x-2 .. x+1, the read register holds x+2
  always_comb begin
    dbit = {win_q[1].two, win_q[2].two, win_q[3].two,
            win_q[0].above, win_q[1].above, win_q[2].above, win_q[3].above, rd_q.above,
            left_q[1], left_q[0]};
    dok  = {cm1 && rm2, c0 && rm2, cp1 && rm2,
            cm2 && rm1, cm1 && rm1, c0 && rm1, cp1 && rm1, cp2 && rm1,
            cm2 && r0, cm1 && r0};
    pack = '0;
    for (int i = 0; i < TmplLen; i++) begin
      dig[i] = dok[TmplLen-1-i] ? {1'b0, dbit[TmplLen-1-i]} : 2'(DigitRadix - 1);
      case (dig[i])
        2'd1:    pack = pack + Pow3[i];
        2'd2:    pack = pack + (Pow3[i] << 1);
        default: pack = pack;
      endcase
    end
  end

  // line store: one read ahead per pixel, column written as its pixel passes
  assign ls_we    = accept_pix;
  assign ls_re    = pf_on_q || accept_pix;
  assign ls_raddr = pf_on_q ? ColBits'(pf_cnt_q) : col_q + ColBits'(3);

  always_ff @(posedge clk_i) begin
    if (ls_we) begin
      lstore_q[col_q] <= '{above: in_pixel_i, two: win_q[2].above};
    end
    if (ls_re) begin
      rd_q <= lstore_q[ls_raddr];
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= win_q[3];
      win_q[3] <= rd_q;
    end
  end

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    left_d   = left_q;
    pf_on_d  = pf_on_q;
    pf_cnt_d = pf_cnt_q;
    if (pf_on_q) begin
      pf_cnt_d = pf_cnt_q + 2'd1;
      if (pf_cnt_q == 2'(PrefetchLen - 1)) begin
        pf_on_d = 1'b0;
      end
    end else if (accept_pix) begin
      if (last_col) begin
        col_d    = '0;
        left_d   = '0;
        row_d    = last_row ? '0 : row_q + RowBits'(1);
        pf_on_d  = 1'b1;
        pf_cnt_d = '0;
      end else begin
        col_d  = col_q + ColBits'(1);
        left_d = {left_q[0], in_pixel_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      left_q   <= '0;
      pf_on_q  <= 1'b1;
      pf_cnt_q <= '0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      left_q   <= left_d;
      pf_on_q  <= pf_on_d;
      pf_cnt_q <= pf_cnt_d;
    end
  end

  // hash: multiply in stage two, fold 2^20 as 1025 and reduce in stage three
  assign hsum  = {1'b0, s1_pack_q} + (PackBits+1)'(s1_pack_q[2:0]);
  assign hprod = (HashBits+1)'(hsum) * (HashBits+1)'(HashMul);
  assign fold  = (CtxBits+1)'(s2_hash_q[CtxBits-1:0])
               + (CtxBits+1)'(s2_hash_q[HashBits-1:CtxBits]) * (CtxBits+1)'(FoldMul);
  assign ctx   = (fold >= (CtxBits+1)'(TableSize)) ?
                 CtxBits'(fold - (CtxBits+1)'(TableSize)) : CtxBits'(fold);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (ld2) begin
        s1_v_q <= 1'b0;
      end
      if (ld2) begin
        s2_v_q <= 1'b1;
      end else if (ld3) begin
        s2_v_q <= 1'b0;
      end
      if (ld3) begin
        s3_v_q <= 1'b1;
      end else if (push_o) begin
        s3_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q      <= '{action: in_action_i, pixel: in_pixel_i,
                     mark_end: last_col && last_row, ctx: '0};
      s1_pack_q <= pack;
    end
    if (ld2) begin
      s2_q      <= s1_q;
      s2_hash_q <= HashBits'(s1_pack_q) ^ HashBits'(hprod);
    end
    if (ld3) begin
      s3_q <= '{action: s2_q.action, pixel: s2_q.pixel,
                mark_end: s2_q.mark_end, ctx: ctx};
    end
  end

  assign work_o = s3_q;

endmodule

// ----- rtl/btcm_queue.sv -----
// short word queue between the front and the back
module btcm_queue import btcm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t work_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output work_t work_o
);

  work_t               slot_q [QueueDepth];
  logic [QPtrBits-1:0] wr_q, rd_q;
  logic [QPtrBits:0]   cnt_q;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == (QPtrBits+1)'(QueueDepth);
  assign work_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= work_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPtrBits'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPtrBits'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (QPtrBits+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QPtrBits+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- rtl/btcm_back.sv -----
// back: count table read-modify-write, clear sweep and result register
module btcm_back import btcm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 q_valid_i,
  input  work_t                q_work_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CtxBits-1:0]   out_ctx_o,
  output logic [CountBits-1:0] out_white_o,
  output logic [CountBits-1:0] out_black_o,
  output logic                 out_last_o,
  output logic                 out_clear_o
);

  typedef struct packed {
    logic [CountBits-1:0] white;
    logic [CountBits-1:0] black;
  } cpair_t;

  typedef enum logic [1:0] {
    ST_FLOW,
    ST_SWEEP,
    ST_HOLD
  } state_e;

  localparam logic [CountBits-1:0] CountMax = '1;

  cpair_t               table_q [TableSize];
  cpair_t               rd_q;
  state_e               st_q;
  logic                 b2_v_q;
  work_t                b2_q;
  logic [CtxBits-1:0]   clr_q;
  logic                 fwd_v_q;
  logic [CtxBits-1:0]   fwd_ctx_q;
  cpair_t               fwd_q;
  logic                 out_v_q, out_last_q, out_clear_q;
  logic [CtxBits-1:0]   out_ctx_q;
  cpair_t               out_cnt_q;

  cpair_t               cur, upd, init_pair;
  logic [CountBits:0]   bump, tot;
  logic [CountBits-1:0] bumped;
  logic                 b2_leave, pix_write;
  logic                 tb_we;
  logic [CtxBits-1:0]   tb_waddr;
  cpair_t               tb_wdata;

  assign b2_leave  = b2_v_q && (st_q == ST_FLOW || st_q == ST_HOLD)
                   && (!out_v_q || out_ready_i);
  assign pix_write = b2_leave && (st_q == ST_FLOW);
  assign q_pop_o   = q_valid_i && (st_q != ST_SWEEP) && (!b2_v_q || b2_leave);
  assign init_pair = '{white: CountBits'(cfg_i.init), black: CountBits'(cfg_i.init)};

  // a write at the edge that issued this read is not in the read data
  always_comb begin
    cur    = (fwd_v_q && fwd_ctx_q == b2_q.ctx) ? fwd_q : rd_q;
    bump   = {1'b0, (b2_q.pixel ? cur.black : cur.white)} + (CountBits+1)'(cfg_i.step);
    bumped = bump[CountBits] ? CountMax : bump[CountBits-1:0];
    upd    = cur;
    if (b2_q.pixel) begin
      upd.black = bumped;
    end else begin
      upd.white = bumped;
    end
    tot = {1'b0, upd.white} + {1'b0, upd.black};
    if (tot > (CountBits+1)'(cfg_i.limit)) begin
      upd.white = CountBits'(({1'b0, upd.white} + (CountBits+1)'(1)) >> 1);
      upd.black = CountBits'(({1'b0, upd.black} + (CountBits+1)'(1)) >> 1);
    end
  end

  always_comb begin
    tb_we    = pix_write;
    tb_waddr = b2_q.ctx;
    tb_wdata = upd;
    if (st_q == ST_SWEEP) begin
      tb_we    = 1'b1;
      tb_waddr = clr_q;
      tb_wdata = init_pair;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tb_we) begin
      table_q[tb_waddr] <= tb_wdata;
    end
    if (q_pop_o) begin
      rd_q <= table_q[q_work_i.ctx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_FLOW;
      b2_v_q      <= 1'b0;
      b2_q        <= '0;
      clr_q       <= '0;
      fwd_v_q     <= 1'b0;
      fwd_ctx_q   <= '0;
      fwd_q       <= '0;
      out_v_q     <= 1'b0;
      out_ctx_q   <= '0;
      out_cnt_q   <= '0;
      out_last_q  <= 1'b0;
      out_clear_q <= 1'b0;
    end else begin
      if (b2_leave) begin
        out_v_q <= 1'b1;
        if (st_q == ST_HOLD) begin
          out_ctx_q   <= '0;
          out_cnt_q   <= '0;
          out_last_q  <= 1'b0;
          out_clear_q <= 1'b1;
        end else begin
          out_ctx_q   <= b2_q.ctx;
          out_cnt_q   <= cur;
          out_last_q  <= b2_q.mark_end;
          out_clear_q <= 1'b0;
        end
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end

      if (q_pop_o) begin
        b2_v_q    <= 1'b1;
        b2_q      <= q_work_i;
        fwd_v_q   <= pix_write;
        fwd_ctx_q <= b2_q.ctx;
        fwd_q     <= upd;
        clr_q     <= '0;
        st_q      <= (q_work_i.action == ACT_CLEAR) ? ST_SWEEP : ST_FLOW;
      end else if (b2_leave) begin
        b2_v_q <= 1'b0;
        st_q   <= ST_FLOW;
      end else if (st_q == ST_SWEEP) begin
        clr_q <= clr_q + CtxBits'(1);
        if (clr_q == CtxBits'(TableSize - 1)) begin
          st_q <= ST_HOLD;
        end
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_ctx_o   = out_ctx_q;
  assign out_white_o = out_cnt_q.white;
  assign out_black_o = out_cnt_q.black;
  assign out_last_o  = out_last_q;
  assign out_clear_o = out_clear_q;

endmodule
